### rtl/core/msort_pkg.sv
// ----------------------------------------------------------------------------
// msort_pkg
// Shared sizes, types and sequencer states of the merge/split sorter.
// ----------------------------------------------------------------------------
package msort_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [AW-1:0]                addr_t;
  typedef logic [CW-1:0]                cnt_t;

  // Result of one compare-exchange step.
  typedef struct packed {
    logic  swap;  // first operand was the larger one
    data_t lo;    // smaller of the two
    data_t hi;    // larger of the two
  } cmp_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OUTER,
    S_LOAD_I,
    S_INNER,
    S_WB,
    S_EMIT
  } state_e;

endpackage

### rtl/core/msort_ram.sv
// ----------------------------------------------------------------------------
// msort_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module msort_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/core/msort_cmp.sv
// ----------------------------------------------------------------------------
// msort_cmp
// Shared signed compare-exchange unit: orders two words.
// ----------------------------------------------------------------------------
module msort_cmp (
  input  msort_pkg::data_t    a_i,
  input  msort_pkg::data_t    b_i,
  output msort_pkg::cmp_res_t res_o
);
  import msort_pkg::*;

  logic gt;

  assign gt        = (a_i > b_i);  // both operands signed
  assign res_o.swap = gt;
  assign res_o.lo   = gt ? b_i : a_i;
  assign res_o.hi   = gt ? a_i : b_i;

endmodule

### rtl/core/merge_split_sorter.sv
// ----------------------------------------------------------------------------
// merge_split_sorter
// Loads two tagged arrays, exchange-sorts them in one store, and emits them.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a word (value_i, to_second_i, last_i) is taken on a clock
//   edge where start is high and busy is low. Words are stored in arrival
//   order, one per cycle, while busy stays low. Words past the store depth
//   are dropped and the set is marked overflowed. The word with last_i set
//   ends the set; busy then rises until every result has been sent.
//   Sorting: one signed compare-exchange unit runs over the store RAM. For
//   each position i the running minimum sits in a register and is compared
//   with every later entry, one entry per cycle; the larger word goes back
//   to the RAM. With n stored words the sort makes n(n-1)/2 compares,
//   plus S_OUTER, S_LOAD_I, S_WB per pass, bounded by the single RAM read port.
//   Output channel: n results, one per cycle back to back, each on valid_o
//   for exactly one cycle. The first first-array-count results carry
//   in_second_o = 0, the rest 1; final_res_o marks the last one; overflow_o
//   is set on all results of an overflowed set. Result 1 is read from the
//   RAM after the final outer check, then registered. The receiver cannot stall.
//   busy drops as the sequencer returns from S_EMIT to S_IDLE, while the
//   final result is loaded into the output registers.
//   Reset: counters, overflow flag and sequencer clear; store contents are
//   left as they are, since only written entries are ever used.
// ----------------------------------------------------------------------------
module merge_split_sorter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  msort_pkg::data_t value_i,
  input  logic             to_second_i,
  input  logic             last_i,
  output logic             valid_o,
  output msort_pkg::data_t sorted_value_o,
  output logic             in_second_o,
  output logic             final_res_o,
  output logic             overflow_o
);
  import msort_pkg::*;

  state_e   state_q, state_d;
  cnt_t     total_q, total_d;   // stored words
  cnt_t     first_q, first_d;   // stored first-array words
  logic     ovf_q, ovf_d;
  cnt_t     i_q, i_d;           // outer position
  cnt_t     k_q, k_d;           // inner position, also emit index
  data_t    cur_q, cur_d;       // running minimum for position i

  logic     out_valid_q, out_valid_d;
  data_t    out_value_q, out_value_d;
  logic     out_second_q, out_second_d;
  logic     out_final_q, out_final_d;
  logic     out_ovf_q, out_ovf_d;

  // RAM port
  logic     mem_we;
  addr_t    mem_waddr;
  data_t    mem_wdata;
  addr_t    mem_raddr;
  data_t    mem_rdata;

  cnt_t     i_inc, k_inc;
  cmp_res_t cmp;

  assign i_inc = i_q + cnt_t'(1);
  assign k_inc = k_q + cnt_t'(1);

  msort_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Compare-exchange between running minimum and the word just read.
  msort_cmp u_cmp (
    .a_i   (cur_q),
    .b_i   (mem_rdata),
    .res_o (cmp)
  );

  always_comb begin
    state_d      = state_q;
    total_d      = total_q;
    first_d      = first_q;
    ovf_d        = ovf_q;
    i_d          = i_q;
    k_d          = k_q;
    cur_d        = cur_q;
    out_valid_d  = 1'b0;
    out_value_d  = out_value_q;
    out_second_d = out_second_q;
    out_final_d  = out_final_q;
    out_ovf_d    = out_ovf_q;
    mem_we       = 1'b0;
    mem_waddr    = i_q[AW-1:0];
    mem_wdata    = cur_q;
    mem_raddr    = k_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          if (total_q < cnt_t'(DEPTH)) begin
            mem_we    = 1'b1;
            mem_waddr = total_q[AW-1:0];
            mem_wdata = value_i;
            total_d   = total_q + cnt_t'(1);
            if (!to_second_i) begin
              first_d = first_q + cnt_t'(1);
            end
          end else begin
            ovf_d = 1'b1;  // store full, word dropped
          end
          if (last_i) begin
            i_d     = '0;
            state_d = S_OUTER;
          end
        end
      end

      S_OUTER: begin
        if (i_inc < total_q) begin
          mem_raddr = i_q[AW-1:0];
          k_d       = i_inc;
          state_d   = S_LOAD_I;
        end else begin
          // sort done, prefetch the first result
          mem_raddr = '0;
          k_d       = '0;
          state_d   = S_EMIT;
        end
      end

      S_LOAD_I: begin
        cur_d     = mem_rdata;
        mem_raddr = k_q[AW-1:0];
        state_d   = S_INNER;
      end

      S_INNER: begin
        // larger word goes back to slot k, smaller stays as running min
        mem_we    = cmp.swap;
        mem_waddr = k_q[AW-1:0];
        mem_wdata = cmp.hi;
        cur_d     = cmp.lo;
        mem_raddr = k_inc[AW-1:0];
        if (k_inc < total_q) begin
          k_d = k_inc;
        end else begin
          state_d = S_WB;
        end
      end

      S_WB: begin
        mem_we    = 1'b1;
        mem_waddr = i_q[AW-1:0];
        mem_wdata = cur_q;
        i_d       = i_inc;
        state_d   = S_OUTER;
      end

      S_EMIT: begin
        out_valid_d  = 1'b1;
        out_value_d  = mem_rdata;
        out_second_d = (k_q >= first_q);
        out_final_d  = (k_inc == total_q);
        out_ovf_d    = ovf_q;
        mem_raddr    = k_inc[AW-1:0];  // wraps harmlessly past the end
        if (k_inc == total_q) begin
          total_d = '0;
          first_d = '0;
          ovf_d   = 1'b0;
          state_d = S_IDLE;
        end else begin
          k_d = k_inc;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      total_q     <= '0;
      first_q     <= '0;
      ovf_q       <= 1'b0;
      i_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      first_q     <= first_d;
      ovf_q       <= ovf_d;
      i_q         <= i_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    out_value_q  <= out_value_d;
    out_second_q <= out_second_d;
    out_final_q  <= out_final_d;
    out_ovf_q    <= out_ovf_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign valid_o        = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign in_second_o    = out_second_q;
  assign final_res_o    = out_final_q;
  assign overflow_o     = out_ovf_q;

  // Assertions
  a_last_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_i) |=> busy)
    else $error("last word did not start the sort");

  a_results_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !final_res_o) |=> valid_o)
    else $error("gap inside a result burst");

  a_gap_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && final_res_o) |=> !valid_o)
    else $error("result after final result");

  a_inner_after_outer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INNER) |-> ((k_q > i_q) && (k_q < total_q)))
    else $error("inner index out of range");

  a_first_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q <= total_q)
    else $error("first-array count exceeds total");

endmodule
